// File: src/sbts_pkg.sv
// ----------------------------------------------------------------------------
// sbts_pkg
// Shared types and codes for the shortest-burst task selector.
// ----------------------------------------------------------------------------
package sbts_pkg;

    localparam int IDENT_W   = 8;
    localparam int PRIO_W    = 8;
    localparam int BURST_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SELECT = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_FRONT = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDENT_W-1:0]  ident;
        logic [PRIO_W-1:0]   prio;
        logic [BURST_W-1:0]  burst;
        logic [OCC_W-1:0]    occ;
    } result_t;

endpackage

// File: src/sbts_table.sv
// ----------------------------------------------------------------------------
// sbts_table
// Task table storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module sbts_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/shortest_burst_task_selector_core.sv
// ----------------------------------------------------------------------------
// shortest_burst_task_selector_core
// Bounded task table in list order with shortest-burst selection.
// ----------------------------------------------------------------------------
// Input channel s_*: one transaction per request. s_tuser selects insert (0)
// or select (1); s_tdata carries the task to append on an insert.
// Result channel m_*: exactly one result transaction per request, in order.
// m_tuser is the status, m_tdata the chosen task and the occupancy.
// Throughput: one request at a time; s_tready is high only while idle.
// An insert or an empty select goes via the result register and the DONE
// state to the output register. A select makes one pass of the shared burst
// comparator over the n held tasks (one entry per cycle through the registered
// read port), shifts the b entries ahead of the chosen task, at list position
// b, back one place, one entry per cycle, then writes it to the front.
// Reset clears the task count and the output valid; table contents are
// only read once written. If the receiver stalls, the finished result waits
// in the output register; a later result then holds the sequencer in DONE.
// ----------------------------------------------------------------------------
module shortest_burst_task_selector_core #(
    parameter int TABLE_DEPTH = 16,
    parameter int BURST_BITS  = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // task_ident [7:0], task_priority [15:8], task_burst [31:16]
    input  logic [sbts_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type [0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // chosen_ident [7:0], chosen_priority [15:8], chosen_burst [31:16],
    // occupancy [36:32], zero [39:37]
    output logic [sbts_pkg::M_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [sbts_pkg::STATUS_W-1:0]  m_tuser
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = sbts_pkg::IDENT_W + sbts_pkg::PRIO_W + BURST_BITS;
    localparam int BLO   = sbts_pkg::IDENT_W + sbts_pkg::PRIO_W;

    sbts_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]     best_idx_reg, best_idx_next;
    logic [ENT_W-1:0]  best_ent_reg, best_ent_next;
    logic [AW-1:0]     sh_reg, sh_next;
    logic [AW-1:0]     wa_reg, wa_next;
    logic              sh_end_reg, sh_end_next;
    logic              pend_reg, pend_next;
    sbts_pkg::result_t res_reg, res_next;
    sbts_pkg::result_t out_reg, out_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic [AW-1:0]     rd_addr;
    logic [ENT_W-1:0]  rd_data;

    logic [BURST_BITS-1:0]        in_burst;
    logic [ENT_W-1:0]             in_ent;
    logic [CW-1:0]                ptr_m1;
    logic                         s_accept;
    logic                         out_free;
    logic [sbts_pkg::BURST_W-1:0] best_burst16;

    function automatic logic [sbts_pkg::OCC_W-1:0] to_occ(input logic [CW-1:0] c);
        logic [sbts_pkg::OCC_W-1:0] o;
        o = '0;
        for (int i = 0; i < sbts_pkg::OCC_W; i++) begin
            if (i < CW) begin
                o[i] = c[i];
            end
        end
        return o;
    endfunction

    sbts_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .WIDTH (ENT_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        in_burst     = '0;
        best_burst16 = '0;
        for (int i = 0; i < BURST_BITS; i++) begin
            if (i < sbts_pkg::BURST_W) begin
                in_burst[i] = s_tdata[16 + i];
            end
        end
        for (int i = 0; i < sbts_pkg::BURST_W; i++) begin
            if (i < BURST_BITS) begin
                best_burst16[i] = best_ent_reg[BLO + i];
            end
        end
    end

    assign in_ent   = {in_burst, s_tdata[15:8], s_tdata[7:0]};
    assign ptr_m1   = ptr_reg - CW'(1);
    assign s_tready = (state_reg == sbts_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        best_idx_next = best_idx_reg;
        best_ent_next = best_ent_reg;
        sh_next       = sh_reg;
        wa_next       = wa_reg;
        sh_end_next   = sh_end_reg;
        pend_next     = pend_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        wr_en         = 1'b0;
        wr_addr       = count_reg[AW-1:0];
        wr_data       = in_ent;
        rd_addr       = ptr_reg[AW-1:0];

        case (state_reg)
            sbts_pkg::ST_IDLE: begin
                if (s_accept) begin
                    res_next = '0;
                    if (s_tuser == sbts_pkg::REQ_INSERT) begin
                        if (count_reg < CW'(TABLE_DEPTH)) begin
                            wr_en           = 1'b1;
                            count_next      = count_reg + CW'(1);
                            res_next.status = sbts_pkg::STAT_OK;
                            res_next.occ    = to_occ(count_reg + CW'(1));
                        end else begin
                            res_next.status = sbts_pkg::STAT_FULL;
                            res_next.occ    = to_occ(count_reg);
                        end
                        state_next = sbts_pkg::ST_DONE;
                    end else if (count_reg == '0) begin
                        res_next.status = sbts_pkg::STAT_EMPTY;
                        state_next      = sbts_pkg::ST_DONE;
                    end else begin
                        ptr_next   = '0;
                        state_next = sbts_pkg::ST_SCAN;
                    end
                end
            end
            sbts_pkg::ST_SCAN: begin
                // read entry ptr while comparing entry ptr-1
                if (ptr_reg != '0) begin
                    if (ptr_reg == CW'(1) ||
                        rd_data[ENT_W-1:BLO] < best_ent_reg[ENT_W-1:BLO]) begin
                        best_ent_next = rd_data;
                        best_idx_next = ptr_m1[AW-1:0];
                    end
                end
                ptr_next = ptr_reg + CW'(1);
                if (ptr_reg == count_reg) begin
                    sh_next     = best_idx_next - AW'(1);
                    sh_end_next = (best_idx_next == '0);
                    pend_next   = 1'b0;
                    state_next  = sbts_pkg::ST_SHIFT;
                end
            end
            sbts_pkg::ST_SHIFT: begin
                // move entries ahead of the chosen one back by one place
                wr_en   = pend_reg;
                wr_addr = wa_reg;
                wr_data = rd_data;
                rd_addr = sh_reg;
                if (!sh_end_reg) begin
                    pend_next = 1'b1;
                    wa_next   = sh_reg + AW'(1);
                    if (sh_reg == '0) begin
                        sh_end_next = 1'b1;
                    end else begin
                        sh_next = sh_reg - AW'(1);
                    end
                end else begin
                    pend_next  = 1'b0;
                    state_next = sbts_pkg::ST_FRONT;
                end
            end
            sbts_pkg::ST_FRONT: begin
                wr_en           = 1'b1;
                wr_addr         = '0;
                wr_data         = best_ent_reg;
                res_next.status = sbts_pkg::STAT_OK;
                res_next.ident  = best_ent_reg[sbts_pkg::IDENT_W-1:0];
                res_next.prio   = best_ent_reg[BLO-1:sbts_pkg::IDENT_W];
                res_next.burst  = best_burst16;
                res_next.occ    = to_occ(count_reg);
                state_next      = sbts_pkg::ST_DONE;
            end
            sbts_pkg::ST_DONE: begin
                if (out_free) begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = sbts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sbts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sbts_pkg::ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            sh_end_reg   <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            sh_end_reg   <= sh_end_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg      <= ptr_next;
        best_idx_reg <= best_idx_next;
        best_ent_reg <= best_ent_next;
        sh_reg       <= sh_next;
        wa_reg       <= wa_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'b000, out_reg.occ, out_reg.burst, out_reg.prio, out_reg.ident};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("task count above table depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == sbts_pkg::REQ_INSERT && count_reg < CW'(TABLE_DEPTH)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not add a task");

    a_select_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == sbts_pkg::REQ_SELECT |=> $stable(count_reg))
        else $error("select changed the task count");

    a_shift_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sbts_pkg::ST_SHIFT |-> {1'b0, best_idx_reg} < {1'b0, count_reg})
        else $error("chosen entry beyond held tasks");

    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_reg.status == sbts_pkg::STAT_EMPTY |-> out_reg.occ == '0)
        else $error("empty status with nonzero occupancy");

endmodule
